FILE: sv/umr_pkg.sv
package umr_pkg;

    localparam int FIFO_DEPTH = 8;
    localparam int FIFO_AW = $clog2(FIFO_DEPTH);
    localparam int MAX_BYTES = 4;

    localparam logic [4:0] MOD26 = 5'd26;
    localparam logic [4:0] MOD25 = 5'd25;
    localparam logic [4:0] MOD10 = 5'd10;

    localparam logic [20:0] CP_REPLACEMENT = 21'h00FFFD;
    localparam logic [20:0] BASE_UPPER = 21'h000041;
    localparam logic [20:0] BASE_LOWER = 21'h000061;
    localparam logic [20:0] BASE_GREEK_UPPER = 21'h000391;
    localparam logic [20:0] BASE_GREEK_LOWER = 21'h0003B1;
    localparam logic [20:0] BASE_CIRCLED_UPPER = 21'h0024B6;
    localparam logic [20:0] BASE_CIRCLED_LOWER = 21'h0024D0;
    localparam logic [20:0] BASE_DIGIT = 21'h000030;

    localparam logic [7:0] CONT_MASK = 8'h3F;
    localparam logic [7:0] LEAD2 = 8'hC0;
    localparam logic [7:0] LEAD3 = 8'hE0;
    localparam logic [7:0] LEAD4 = 8'hF0;
    localparam logic [7:0] CONT_MARK = 8'h80;

    localparam logic [2:0] ADDR_SHIFT_KEY = 3'd0;
    localparam logic [2:0] ADDR_INVERSE_MODE = 3'd4;

    typedef logic [255:0][4:0] mod_tab_t;

    typedef struct packed {
        logic [4:0] k26;
        logic [4:0] k25;
        logic [3:0] k10;
    } key_set_t;

    typedef struct packed {
        logic       text_done;
        logic       char_done;
        logic [7:0] coded_byte;
    } out_item_t;

    typedef struct packed {
        logic [2:0]                     count;
        out_item_t [MAX_BYTES-1:0]      items;
    } burst_t;

    // residue of one key byte; the high byte carries the sign of the key
    function automatic mod_tab_t build_tab(input int m, input bit high_byte);
        mod_tab_t t;
        int v;
        for (int i = 0; i < 256; i++)
        begin
            if (high_byte)
                v = ((i >= 128) ? (i - 256) : i) * 256;
            else
                v = i;
            while (v < 0)
                v = v + m;
            while (v >= m)
                v = v - m;
            t[i] = 5'(v);
        end
        return t;
    endfunction

    localparam mod_tab_t HI_TAB26 = build_tab(26, 1'b1);
    localparam mod_tab_t LO_TAB26 = build_tab(26, 1'b0);
    localparam mod_tab_t HI_TAB25 = build_tab(25, 1'b1);
    localparam mod_tab_t LO_TAB25 = build_tab(25, 1'b0);
    localparam mod_tab_t HI_TAB10 = build_tab(10, 1'b1);
    localparam mod_tab_t LO_TAB10 = build_tab(10, 1'b0);

endpackage

FILE: sv/umr_key.sv
module umr_key
    import umr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [15:0] shift_key,
    input  logic        inverse_mode,
    output key_set_t    keys
);

    key_set_t keys_reg;
    key_set_t keys_next;

    function automatic logic [4:0] combine(input logic [4:0] a, input logic [4:0] b,
                                           input logic [4:0] m, input logic inv);
        logic [5:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        if (inv && (s != 6'd0))
            s = {1'b0, m} - s;
        return s[4:0];
    endfunction

    logic [4:0] k10_full;

    always_comb
    begin
        keys_next.k26 = combine(HI_TAB26[shift_key[15:8]], LO_TAB26[shift_key[7:0]],
                                MOD26, inverse_mode);
        keys_next.k25 = combine(HI_TAB25[shift_key[15:8]], LO_TAB25[shift_key[7:0]],
                                MOD25, inverse_mode);
        k10_full = combine(HI_TAB10[shift_key[15:8]], LO_TAB10[shift_key[7:0]],
                           MOD10, inverse_mode);
        keys_next.k10 = k10_full[3:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            keys_reg <= '0;
        else
            keys_reg <= keys_next;
    end

    assign keys = keys_reg;

endmodule

FILE: sv/umr_core.sv
module umr_core
    import umr_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       fire,
    input  logic [7:0] text_byte,
    input  logic       final_byte,
    input  key_set_t   keys,
    output burst_t     burst
);

    logic [20:0] partial_reg;
    logic [20:0] partial_next;
    logic [1:0]  pending_reg;
    logic [1:0]  pending_next;

    function automatic logic [20:0] rot_range(input logic [20:0] cp, input logic [20:0] base,
                                              input logic [4:0] k, input logic [4:0] m);
        logic [4:0] off;
        logic [5:0] s;
        off = 5'(cp - base);
        s = {1'b0, off} + {1'b0, k};
        if (s >= {1'b0, m})
            s = s - {1'b0, m};
        return base + 21'(s);
    endfunction

    function automatic logic [20:0] rotate(input logic [20:0] cp, input key_set_t k);
        logic [20:0] r;
        r = cp;
        if (cp >= BASE_UPPER && cp <= BASE_UPPER + 21'd25)
            r = rot_range(cp, BASE_UPPER, k.k26, MOD26);
        else if (cp >= BASE_LOWER && cp <= BASE_LOWER + 21'd25)
            r = rot_range(cp, BASE_LOWER, k.k26, MOD26);
        else if (cp >= BASE_GREEK_UPPER && cp <= BASE_GREEK_UPPER + 21'd24)
            r = rot_range(cp, BASE_GREEK_UPPER, k.k25, MOD25);
        else if (cp >= BASE_GREEK_LOWER && cp <= BASE_GREEK_LOWER + 21'd24)
            r = rot_range(cp, BASE_GREEK_LOWER, k.k25, MOD25);
        else if (cp >= BASE_CIRCLED_UPPER && cp <= BASE_CIRCLED_UPPER + 21'd25)
            r = rot_range(cp, BASE_CIRCLED_UPPER, k.k26, MOD26);
        else if (cp >= BASE_CIRCLED_LOWER && cp <= BASE_CIRCLED_LOWER + 21'd25)
            r = rot_range(cp, BASE_CIRCLED_LOWER, k.k26, MOD26);
        else if (cp >= BASE_DIGIT && cp <= BASE_DIGIT + 21'd9)
            r = rot_range(cp, BASE_DIGIT, {1'b0, k.k10}, MOD10);
        return r;
    endfunction

    function automatic burst_t encode(input logic [20:0] cp, input logic last);
        burst_t b;
        logic [7:0] c0, c1, c2, c3;
        logic [2:0] n;
        c0 = 8'(cp);
        c1 = 8'h00;
        c2 = 8'h00;
        c3 = 8'h00;
        if (cp <= 21'h7F)
        begin
            n = 3'd1;
        end
        else if (cp <= 21'h7FF)
        begin
            c0 = LEAD2 | 8'(cp >> 6);
            c1 = CONT_MARK | (8'(cp) & CONT_MASK);
            n = 3'd2;
        end
        else if (cp <= 21'hFFFF)
        begin
            c0 = LEAD3 | 8'(cp >> 12);
            c1 = CONT_MARK | (8'(cp >> 6) & CONT_MASK);
            c2 = CONT_MARK | (8'(cp) & CONT_MASK);
            n = 3'd3;
        end
        else
        begin
            c0 = LEAD4 | 8'(cp >> 18);
            c1 = CONT_MARK | (8'(cp >> 12) & CONT_MASK);
            c2 = CONT_MARK | (8'(cp >> 6) & CONT_MASK);
            c3 = CONT_MARK | (8'(cp) & CONT_MASK);
            n = 3'd4;
        end
        b.count = n;
        b.items[0].coded_byte = c0;
        b.items[1].coded_byte = c1;
        b.items[2].coded_byte = c2;
        b.items[3].coded_byte = c3;
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            b.items[i].char_done = (3'(i) == n - 3'd1);
            b.items[i].text_done = last && (3'(i) == n - 3'd1);
        end
        return b;
    endfunction

    logic [20:0] merged;
    logic [1:0]  pend_dec;
    logic        complete;
    logic [20:0] done_cp;

    always_comb
    begin
        partial_next = partial_reg;
        pending_next = pending_reg;
        complete = 1'b0;
        done_cp = 21'd0;
        pend_dec = pending_reg - 2'd1;
        merged = (partial_reg | (21'(text_byte & CONT_MASK) << (5'd6 * 5'(pend_dec))));
        burst = '0;

        if (pending_reg == 2'd0)
        begin
            if (!text_byte[7])
            begin
                complete = 1'b1;
                done_cp = 21'(text_byte);
            end
            else if ((text_byte & 8'hE0) == LEAD2)
            begin
                partial_next = 21'(text_byte & 8'h1F) << 6;
                pending_next = 2'd1;
            end
            else if ((text_byte & 8'hF0) == LEAD3)
            begin
                partial_next = 21'(text_byte & 8'h0F) << 12;
                pending_next = 2'd2;
            end
            else
            begin
                partial_next = 21'(text_byte & 8'h07) << 18;
                pending_next = 2'd3;
            end
        end
        else
        begin
            partial_next = merged;
            pending_next = pend_dec;
            if (pend_dec == 2'd0)
            begin
                complete = 1'b1;
                done_cp = merged;
                partial_next = 21'd0;
            end
        end

        if (complete)
        begin
            burst = encode(rotate(done_cp, keys), final_byte);
        end
        else if (final_byte)
        begin
            partial_next = 21'd0;
            pending_next = 2'd0;
            burst = encode(CP_REPLACEMENT, 1'b1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            partial_reg <= 21'd0;
            pending_reg <= 2'd0;
        end
        else if (fire)
        begin
            partial_reg <= partial_next;
            pending_reg <= pending_next;
        end
    end

endmodule

FILE: sv/umr_fifo.sv
module umr_fifo
    import umr_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      wr_en,
    input  burst_t    burst,
    output logic      room,
    output logic      rd_valid,
    input  logic      rd_ready,
    output out_item_t rd_item
);

    out_item_t mem_reg [FIFO_DEPTH];

    logic [FIFO_AW-1:0] wr_ptr_reg;
    logic [FIFO_AW-1:0] wr_ptr_next;
    logic [FIFO_AW-1:0] rd_ptr_reg;
    logic [FIFO_AW-1:0] rd_ptr_next;
    logic [FIFO_AW:0]   count_reg;
    logic [FIFO_AW:0]   count_next;
    logic [2:0]         wr_count;
    logic               rd_en;

    assign wr_count = wr_en ? burst.count : 3'd0;
    assign rd_valid = (count_reg != '0);
    assign rd_en = rd_valid && rd_ready;
    assign room = (count_reg <= (FIFO_AW+1)'(FIFO_DEPTH - MAX_BYTES));
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_AW'(wr_count);
        rd_ptr_next = rd_ptr_reg + FIFO_AW'(rd_en);
        count_next = count_reg + (FIFO_AW+1)'(wr_count) - (FIFO_AW+1)'(rd_en);
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_BYTES; i++)
        begin
            if (3'(i) < wr_count)
                mem_reg[wr_ptr_reg + FIFO_AW'(i)] <= burst.items[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg <= count_next;
        end
    end

endmodule

FILE: sv/utf8_multirange_rotation.sv
// path: an accepted input byte is held in the stage register, then written into the output buffer
// throughput: one input byte per cycle; the output buffer takes up to 4 bytes a cycle
// and drains one byte per cycle with m_tready high; input stalls below 4 free slots
// reset: rst_n asynchronous, active low; clears decoder state, buffer pointers, stage valid, key and config registers
module utf8_multirange_rotation
    import umr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // text_byte
    input  logic        s_tlast,   // final_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // coded_byte
    output logic        m_tuser,   // char_done
    output logic        m_tlast    // text_done
);

    logic [15:0] shift_key_reg;
    logic [15:0] shift_key_next;
    logic        inverse_mode_reg;
    logic        inverse_mode_next;
    logic        stage_valid_reg;
    logic        stage_valid_next;
    logic [7:0]  stage_byte_reg;
    logic        stage_final_reg;

    logic        cfg_write;
    logic        room;
    logic        fire;
    logic        s_accept;
    key_set_t    keys;
    burst_t      burst;
    out_item_t   rd_item;

    assign pready = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_comb
    begin
        shift_key_next = shift_key_reg;
        inverse_mode_next = inverse_mode_reg;
        if (cfg_write && paddr == ADDR_SHIFT_KEY)
            shift_key_next = pwdata[15:0];
        if (cfg_write && paddr == ADDR_INVERSE_MODE)
            inverse_mode_next = pwdata[0];
    end

    always_comb
    begin
        case (paddr)
            ADDR_SHIFT_KEY:    prdata = {16'd0, shift_key_reg};
            ADDR_INVERSE_MODE: prdata = {31'd0, inverse_mode_reg};
            default:           prdata = 32'd0;
        endcase
    end

    assign fire = stage_valid_reg && room;
    assign s_tready = !stage_valid_reg || room;
    assign s_accept = s_tvalid && s_tready;

    always_comb
    begin
        stage_valid_next = stage_valid_reg;
        if (s_accept)
            stage_valid_next = 1'b1;
        else if (fire)
            stage_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_key_reg <= 16'd0;
            inverse_mode_reg <= 1'b0;
            stage_valid_reg <= 1'b0;
        end
        else
        begin
            shift_key_reg <= shift_key_next;
            inverse_mode_reg <= inverse_mode_next;
            stage_valid_reg <= stage_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            stage_byte_reg <= s_tdata;
            stage_final_reg <= s_tlast;
        end
    end

    umr_key u_key (
        .clk          (clk),
        .rst_n        (rst_n),
        .shift_key    (shift_key_reg),
        .inverse_mode (inverse_mode_reg),
        .keys         (keys)
    );

    umr_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .fire       (fire),
        .text_byte  (stage_byte_reg),
        .final_byte (stage_final_reg),
        .keys       (keys),
        .burst      (burst)
    );

    umr_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (fire),
        .burst    (burst),
        .room     (room),
        .rd_valid (m_tvalid),
        .rd_ready (m_tready),
        .rd_item  (rd_item)
    );

    assign m_tdata = rd_item.coded_byte;
    assign m_tuser = rd_item.char_done;
    assign m_tlast = rd_item.text_done;

endmodule
